[rtl/mss_pkg.sv]
// Shared types, codes and the seven-segment decode table for the display scanner.
package mss_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_REFRESH = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TOGGLE  = 2'd2
  } op_e;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_NUM_DIGITS   = 2'd0,
    REG_FLASH_FIRST  = 2'd1,
    REG_FLASH_LAST   = 2'd2,
    REG_FLASH_PERIOD = 2'd3
  } reg_e;

  localparam int unsigned SegDot   = 7;
  localparam logic [3:0]  NumReset = 4'd8;

  // One input request, unpacked from tdata
  typedef struct packed {
    logic [2:0] range_last;
    logic [2:0] range_first;
    logic [3:0] bcd_digit;
    logic [2:0] position;
    logic       clear_first;
    logic [1:0] operation;
  } item_t;

  // Flash settings handed to the scan controller
  typedef struct packed {
    logic [2:0]  flash_first;
    logic [2:0]  flash_last;
    logic [15:0] flash_period;
  } flash_cfg_t;

  // Configuration write events that touch scan state
  typedef struct packed {
    logic ndig_wr;
    logic flash_wr;
  } cfg_evt_t;

  // BCD to segments A..G, blank for codes ten and up
  function automatic logic [7:0] seg_image(input logic [3:0] bcd);
    logic [7:0] img;
    case (bcd)
      4'd0:    img = 8'h3F;
      4'd1:    img = 8'h06;
      4'd2:    img = 8'h5B;
      4'd3:    img = 8'h4F;
      4'd4:    img = 8'h66;
      4'd5:    img = 8'h6D;
      4'd6:    img = 8'h7D;
      4'd7:    img = 8'h07;
      4'd8:    img = 8'h7F;
      4'd9:    img = 8'h6F;
      default: img = 8'h00;
    endcase
    return img;
  endfunction

endpackage

[rtl/mss_store.sv]
// Segment pattern store: BCD writes with optional clear, dot toggles over a range.
module mss_store #(
  parameter int unsigned MAX_DIGITS = 8,
  parameter int unsigned AW = 3,
  parameter int unsigned NW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_i,
  input  mss_pkg::item_t       item_i,
  input  logic [NW-1:0]        eff_num_i,
  input  logic [AW-1:0]        rd_idx_i,
  output logic [7:0]           rd_seg_o
);
  import mss_pkg::*;

  logic [7:0] pat_q [MAX_DIGITS];
  logic [7:0] pat_d [MAX_DIGITS];
  logic [7:0] img;
  logic       pos_ok;
  int         last_c;

  assign img    = seg_image(item_i.bcd_digit);
  assign pos_ok = (5'(item_i.position) < 5'(eff_num_i));
  assign last_c = (int'(item_i.range_last) > int'(MAX_DIGITS) - 1) ?
                  int'(MAX_DIGITS) - 1 : int'(item_i.range_last);

  // Next value of every entry, all in parallel
  always_comb begin
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      pat_d[i] = pat_q[i];
      if (req_i) begin
        case (op_e'(item_i.operation))
          OP_WRITE: begin
            if (item_i.clear_first) pat_d[i] = 8'h00;
            if (pos_ok && int'(item_i.position) == i) pat_d[i] = img;
          end
          OP_TOGGLE: begin
            if (i >= int'(item_i.range_first) && i <= last_c) begin
              pat_d[i][SegDot] = ~pat_q[i][SegDot];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Hold patterns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_DIGITS); i++) pat_q[i] <= 8'h00;
    end else begin
      for (int i = 0; i < int'(MAX_DIGITS); i++) pat_q[i] <= pat_d[i];
    end
  end

  assign rd_seg_o = pat_q[rd_idx_i];

endmodule

[rtl/mss_scan.sv]
// Scan controller: active digit, whole-scan counter and flash blanking decision.
module mss_scan #(
  parameter int unsigned AW = 3,
  parameter int unsigned NW = 4,
  parameter logic [AW-1:0] RST_ACTIVE = '1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic [NW-1:0]        eff_num_i,
  // Effective digit count carried by a digit-count register write
  input  logic [NW-1:0]        load_num_i,
  input  mss_pkg::flash_cfg_t  cfg_i,
  input  mss_pkg::cfg_evt_t    evt_i,
  output logic [AW-1:0]        active_o,
  output logic [AW-1:0]        nxt_active_o,
  output logic                 blank_o
);
  import mss_pkg::*;

  logic [AW-1:0] active_q, active_d;
  logic [15:0]   scan_q, scan_d;
  logic [NW-1:0] inc;
  logic          wrap;
  logic [16:0]   cnt_inc;
  logic [15:0]   scan_nxt;
  logic          in_range;

  // Advance the active digit modulo the digit count
  assign inc          = NW'(active_q) + NW'(1);
  assign wrap         = (inc >= eff_num_i);
  assign nxt_active_o = wrap ? '0 : AW'(inc);

  // Count whole scans against the flash period
  assign cnt_inc  = {1'b0, scan_q} + 17'd1;
  assign scan_nxt = !wrap ? scan_q :
                    (cnt_inc >= {1'b0, cfg_i.flash_period}) ? 16'd0 : cnt_inc[15:0];

  // Blank in the second half of the period inside the flash range
  assign in_range = (5'(nxt_active_o) >= 5'(cfg_i.flash_first)) &&
                    (5'(nxt_active_o) <= 5'(cfg_i.flash_last));
  assign blank_o  = (cfg_i.flash_period != 16'd0) &&
                    (scan_nxt >= (cfg_i.flash_period >> 1)) && in_range;

  always_comb begin
    active_d = active_q;
    scan_d   = scan_q;
    if (evt_i.ndig_wr) begin
      active_d = AW'(load_num_i - NW'(1));
    end else if (tick_i) begin
      active_d = nxt_active_o;
    end
    if (evt_i.flash_wr) begin
      scan_d = 16'd0;
    end else if (tick_i) begin
      scan_d = scan_nxt;
    end
  end

  // Hold scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= RST_ACTIVE;
      scan_q   <= 16'd0;
    end else begin
      active_q <= active_d;
      scan_q   <= scan_d;
    end
  end

  assign active_o = active_q;

endmodule

[rtl/multiplexed_seven_segment_scanner.sv]
// Top level of the multiplexed seven-segment scanner: ports, registers, result stage.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid/tready           tdata[15:0] item (write, toggle, refresh tick)
//  m_axis    out  tvalid/tready           tdata[15:0] segments, digit_select
//  apb       in   psel/penable/pwrite     paddr[3:0], pwdata/prdata[31:0]
//
// On each accepted request the store or the scan counter updates and the
// refresh result lands in the output register at the same edge as acceptance.
// One item per cycle is sustained while the output is free or being taken.
// A stalled result holds its register; a new request enters only as it leaves.
// Reset clears all patterns and makes the digit count eight; no clearing pass.
module multiplexed_seven_segment_scanner #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation, [2] clear_first, [5:3] position, [9:6] bcd_digit,
  // [12:10] range_first, [15:13] range_last
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] segments, [10:8] digit_select, [15:11] zero
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mss_pkg::*;

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned RST_NUM = (MAX_DIGITS < 32'(NumReset)) ? MAX_DIGITS :
                                    32'(NumReset);

  logic [3:0]    num_digits_q;
  flash_cfg_t    flash_q;
  logic          cfg_wr;
  reg_e          cfg_reg;
  cfg_evt_t      evt;
  logic [4:0]    num_ext;
  logic [NW-1:0] eff_num;
  logic [4:0]    wr_ext;
  logic [NW-1:0] wr_num;
  item_t         item;
  logic          s_fire;
  logic          tick;
  logic [AW-1:0] active;
  logic [AW-1:0] nxt_active;
  logic          blank;
  logic [7:0]    rd_seg;
  logic          out_valid_q;
  logic [7:0]    seg_q;
  logic [2:0]    sel_q;

  // Configuration port decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = reg_e'(paddr[3:2]);
  assign evt.ndig_wr  = cfg_wr && (cfg_reg == REG_NUM_DIGITS);
  assign evt.flash_wr = cfg_wr && (cfg_reg != REG_NUM_DIGITS);

  always_comb begin
    case (cfg_reg)
      REG_NUM_DIGITS:   prdata = {28'd0, num_digits_q};
      REG_FLASH_FIRST:  prdata = {29'd0, flash_q.flash_first};
      REG_FLASH_LAST:   prdata = {29'd0, flash_q.flash_last};
      REG_FLASH_PERIOD: prdata = {16'd0, flash_q.flash_period};
      default:          prdata = 32'd0;
    endcase
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_digits_q  <= NumReset;
      flash_q       <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_NUM_DIGITS:   num_digits_q         <= pwdata[3:0];
        REG_FLASH_FIRST:  flash_q.flash_first  <= pwdata[2:0];
        REG_FLASH_LAST:   flash_q.flash_last   <= pwdata[2:0];
        REG_FLASH_PERIOD: flash_q.flash_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Clamp the digit count to one through MAX_DIGITS
  assign num_ext = {1'b0, num_digits_q};
  assign eff_num = (num_ext == 5'd0) ? NW'(1) :
                   (num_ext > 5'(MAX_DIGITS)) ? NW'(MAX_DIGITS) : NW'(num_ext);

  // Clamp the digit count being written, for the active digit reload
  assign wr_ext = {1'b0, pwdata[3:0]};
  assign wr_num = (wr_ext == 5'd0) ? NW'(1) :
                  (wr_ext > 5'(MAX_DIGITS)) ? NW'(MAX_DIGITS) : NW'(wr_ext);

  // Input request
  assign item          = item_t'(s_axis_tdata);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign tick          = s_fire && (op_e'(item.operation) == OP_REFRESH);

  mss_store #(
    .MAX_DIGITS (MAX_DIGITS),
    .AW         (AW),
    .NW         (NW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (s_fire),
    .item_i    (item),
    .eff_num_i (eff_num),
    .rd_idx_i  (nxt_active),
    .rd_seg_o  (rd_seg)
  );

  mss_scan #(
    .AW         (AW),
    .NW         (NW),
    .RST_ACTIVE (AW'(RST_NUM - 1))
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .eff_num_i    (eff_num),
    .load_num_i   (wr_num),
    .cfg_i        (flash_q),
    .evt_i        (evt),
    .active_o     (active),
    .nxt_active_o (nxt_active),
    .blank_o      (blank)
  );

  // Result register: load on a refresh tick, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      seg_q <= blank ? 8'h00 : rd_seg;
      sel_q <= 3'(nxt_active);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, sel_q, seg_q};

  // Active digit stays inside the digits in use
  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(active) < eff_num)
    else $error("active digit outside digit count");

  // A refresh tick always yields a result next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> m_axis_tvalid)
    else $error("refresh tick produced no result");

  // Writes, toggles and unused codes yield no result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !tick) |=> !m_axis_tvalid)
    else $error("result without refresh tick");

endmodule
